// ===== sv/zero_crossing_tap_times_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the zero-crossing tap timer.
// Each macro builds one labelled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_TAP_TIMES_ASSERT_SVH
`define ZERO_CROSSING_TAP_TIMES_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ZCTT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("zctt: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define ZCTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("zctt: next-cycle check failed");

`endif

// ===== sv/zctt_pkg.sv =====
// ----------------------------------------------------------------------------
// zctt_pkg
// Widths, types and state codes shared by the zero-crossing tap timer.
// ----------------------------------------------------------------------------
package zctt_pkg;

    localparam int INDEX_BITS  = 20;
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int SKIP_BITS   = 16;
    localparam int OUT_BITS    = 36;
    localparam int TIME_BITS   = INDEX_BITS + FRAC_BITS;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;
    localparam int CMP_BITS    = (INDEX_BITS > SKIP_BITS) ? INDEX_BITS : SKIP_BITS;
    localparam int CNT_BITS    = $clog2(FRAC_BITS);

    localparam logic [SKIP_BITS-1:0] SKIP_RESET = SKIP_BITS'(2000);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic kept;
        logic out_free;
    } t_status;

endpackage

// ===== sv/zero_crossing_tap_times.sv =====
// ----------------------------------------------------------------------------
// zero_crossing_tap_times
// Interpolated zero-crossing tap timer: keeps every other sign change after
// the transient skip and reports its time and the interval to the last tap.
//
// Channel   Direction  Handshake            Payload
// sample    in         i_valid / o_ready    i_sample, i_end_of_trace
// tap       out        o_valid / i_ready    o_tap_time, o_interval, o_interval_valid
// config    in         i_cfg_we             i_cfg_wdata (transient skip)
//
// A sample that yields no tap leaves the sample channel ready.
// A sample that yields a tap holds the sample channel off while the
// one-bit-per-cycle restoring divider forms the fraction.
// The result register lets a new sample enter while a tap waits to be taken;
// a tap that finds the register still full waits until it is taken.
// Reset is synchronous and active low; the skip register returns to 2000.
// ----------------------------------------------------------------------------
module zero_crossing_tap_times (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [zctt_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                    i_end_of_trace,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [zctt_pkg::OUT_BITS-1:0]           o_tap_time,
    output logic [zctt_pkg::OUT_BITS-1:0]           o_interval,
    output logic                                    o_interval_valid,
    input  logic                                    i_cfg_we,
    input  logic [zctt_pkg::SKIP_BITS-1:0]          i_cfg_wdata
);

    zctt_pkg::t_cmd    w_cmd;
    zctt_pkg::t_status w_status;

    zctt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    zctt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_sample         (i_sample),
        .i_end_of_trace   (i_end_of_trace),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_tap_time       (o_tap_time),
        .o_interval       (o_interval),
        .o_interval_valid (o_interval_valid)
    );

endmodule

// ===== sv/zctt_ctrl.sv =====
// ----------------------------------------------------------------------------
// zctt_ctrl
// Sequencer: accepts samples, runs the fraction divider for kept crossings
// and hands the finished tap to the output register.
// ----------------------------------------------------------------------------
module zctt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  zctt_pkg::t_status i_status,
    output zctt_pkg::t_cmd    o_cmd
);

    zctt_pkg::t_state              r_state;
    zctt_pkg::t_state              n_state;
    logic [zctt_pkg::CNT_BITS-1:0] r_cnt;
    logic [zctt_pkg::CNT_BITS-1:0] n_cnt;
    logic                          w_accept;

    assign o_ready  = (r_state == zctt_pkg::S_IDLE);
    assign w_accept = i_valid && o_ready;

    assign o_cmd.accept   = w_accept;
    assign o_cmd.div_step = (r_state == zctt_pkg::S_DIV);
    assign o_cmd.load_out = (r_state == zctt_pkg::S_DONE) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            zctt_pkg::S_IDLE: begin
                if (w_accept && i_status.kept) begin
                    n_state = zctt_pkg::S_DIV;
                    n_cnt   = '0;
                end
            end
            zctt_pkg::S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == zctt_pkg::CNT_BITS'(zctt_pkg::FRAC_BITS - 1)) begin
                    n_state = zctt_pkg::S_DONE;
                end
            end
            zctt_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    n_state = zctt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = zctt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zctt_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/zctt_dp.sv =====
// ----------------------------------------------------------------------------
// zctt_dp
// Datapath: trace state, crossing detection, restoring fraction divider,
// tap time and interval arithmetic, and the output register.
// ----------------------------------------------------------------------------
module zctt_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  zctt_pkg::t_cmd                       i_cmd,
    output zctt_pkg::t_status                    o_status,
    input  logic                                 i_cfg_we,
    input  logic [zctt_pkg::SKIP_BITS-1:0]       i_cfg_wdata,
    input  logic signed [zctt_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                 i_end_of_trace,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic [zctt_pkg::OUT_BITS-1:0]        o_tap_time,
    output logic [zctt_pkg::OUT_BITS-1:0]        o_interval,
    output logic                                 o_interval_valid
);

    logic [zctt_pkg::SKIP_BITS-1:0]          r_skip;
    logic signed [zctt_pkg::SAMPLE_BITS-1:0] r_prev;
    logic [zctt_pkg::INDEX_BITS-1:0]         r_idx;
    logic [zctt_pkg::INDEX_BITS-1:0]         n_idx;
    logic                                    r_parity;
    logic [zctt_pkg::OUT_BITS-1:0]           r_last;
    logic                                    r_have;
    logic                                    r_out_valid;

    logic [zctt_pkg::INDEX_BITS-1:0]         r_job_k;
    logic                                    r_job_eot;
    logic [zctt_pkg::MAG_BITS-1:0]           r_rem;
    logic [zctt_pkg::MAG_BITS-1:0]           r_den;
    logic [zctt_pkg::FRAC_BITS-1:0]          r_quo;
    logic [zctt_pkg::OUT_BITS-1:0]           r_tap;
    logic [zctt_pkg::OUT_BITS-1:0]           r_int;
    logic                                    r_iv;

    logic [zctt_pkg::INDEX_BITS-1:0]         w_idx_m1;
    logic                                    w_counting;
    logic                                    w_cross;
    logic                                    w_kept;
    logic [zctt_pkg::MAG_BITS-1:0]           w_prev_x;
    logic [zctt_pkg::MAG_BITS-1:0]           w_cur_x;
    logic [zctt_pkg::MAG_BITS-1:0]           w_mag_p;
    logic [zctt_pkg::MAG_BITS-1:0]           w_mag_s;
    logic [zctt_pkg::MAG_BITS:0]             w_shift;
    logic [zctt_pkg::MAG_BITS:0]             w_den_x;
    logic                                    w_ge;
    logic [zctt_pkg::MAG_BITS-1:0]           w_rem_nx;
    logic [zctt_pkg::TIME_BITS-1:0]          w_time;
    logic [zctt_pkg::OUT_BITS-1:0]           w_time_o;

    assign w_idx_m1   = r_idx - 1'b1;
    assign w_counting = (r_idx != '0) &&
                        (zctt_pkg::CMP_BITS'(w_idx_m1) >= zctt_pkg::CMP_BITS'(r_skip));
    assign w_cross    = ((r_prev < 0) && (i_sample > 0)) || ((r_prev > 0) && (i_sample < 0));
    assign w_kept     = w_counting && w_cross && !r_parity;

    assign o_status.kept     = w_kept;
    assign o_status.out_free = !r_out_valid || i_ready;

    assign w_prev_x = {r_prev[zctt_pkg::SAMPLE_BITS-1], r_prev};
    assign w_cur_x  = {i_sample[zctt_pkg::SAMPLE_BITS-1], i_sample};
    assign w_mag_p  = r_prev[zctt_pkg::SAMPLE_BITS-1] ? (~w_prev_x + 1'b1) : w_prev_x;
    assign w_mag_s  = i_sample[zctt_pkg::SAMPLE_BITS-1] ? (~w_cur_x + 1'b1) : w_cur_x;

    assign w_shift  = {r_rem, 1'b0};
    assign w_den_x  = {1'b0, r_den};
    assign w_ge     = (w_shift >= w_den_x);
    assign w_rem_nx = w_ge ? zctt_pkg::MAG_BITS'(w_shift - w_den_x)
                           : zctt_pkg::MAG_BITS'(w_shift);

    assign w_time   = {r_job_k, r_quo};
    assign w_time_o = zctt_pkg::OUT_BITS'(w_time);

    always_comb begin
        n_idx = r_idx;
        if (r_idx != '1) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip      <= zctt_pkg::SKIP_RESET;
            r_prev      <= '0;
            r_idx       <= '0;
            r_parity    <= 1'b0;
            r_last      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_skip <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_prev <= i_sample;
                r_idx  <= n_idx;
                if (w_counting && w_cross) begin
                    r_parity <= ~r_parity;
                end
                if (i_end_of_trace) begin
                    r_prev   <= '0;
                    r_idx    <= '0;
                    r_parity <= 1'b0;
                    if (!w_kept) begin
                        r_last <= '0;
                        r_have <= 1'b0;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (r_job_eot) begin
                    r_last <= '0;
                    r_have <= 1'b0;
                end else begin
                    r_last <= w_time_o;
                    r_have <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_kept) begin
            r_job_k   <= w_idx_m1;
            r_job_eot <= i_end_of_trace;
            r_rem     <= w_mag_p;
            r_den     <= w_mag_p + w_mag_s;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_nx;
            r_quo <= {r_quo[zctt_pkg::FRAC_BITS-2:0], w_ge};
        end
        if (i_cmd.load_out) begin
            r_tap <= w_time_o;
            r_int <= r_have ? (w_time_o - r_last) : '0;
            r_iv  <= r_have;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_tap_time       = r_tap;
    assign o_interval       = r_int;
    assign o_interval_valid = r_iv;

endmodule

// ===== sv/zctt_checker.sv =====
// ----------------------------------------------------------------------------
// zctt_checker
// Port-level checks for the zero-crossing tap timer, bound to the top level.
// ----------------------------------------------------------------------------
`include "zero_crossing_tap_times_assert.svh"

module zctt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [zctt_pkg::OUT_BITS-1:0] o_interval,
    input logic                          o_interval_valid
);

    // A waiting transaction on the tap channel is not withdrawn.
    `ZCTT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // The first tap of a trace carries a zero interval.
    `ZCTT_ASSERT_SAME(a_first_zero, i_clk, i_rst_n, o_valid && !o_interval_valid, o_interval == '0)

    // A new tap is only produced while the sample channel is held off.
    `ZCTT_ASSERT_SAME(a_rise_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_ready) == 1'b0)

    // Reset empties the result register.
    `ZCTT_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid)

endmodule

bind zero_crossing_tap_times zctt_checker u_zctt_checker (.*);
